>>> hdl/mstc_pkg.sv
// Shared types, constants and the control store for the motor speed/torque controller.
// Depends on nothing; imported by mstc_div and motor_speed_torque_controller.
package mstc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int ROW_W         = 18;
	localparam int REG_W         = 31;
	localparam int AXIS_W        = 3;
	localparam int DIVISOR_W     = 32;
	localparam int APB_ADDR_W    = 5;
	localparam int APB_DATA_W    = 32;
	localparam int IN_TDATA_W    = 184;
	localparam int OUT_TDATA_W   = 96;
	localparam int STEP_W        = 6;

	localparam logic [AXIS_W-1:0] AXIS_NEG_X = 3'd3;
	localparam logic [AXIS_W-1:0] AXIS_NEG_Z = 3'd5;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		REG_MAX_TORQUE   = 3'd0,
		REG_INERTIA_GAIN = 3'd1,
		REG_DAMPING_GAIN = 3'd2,
		REG_AXIS_SELECT  = 3'd3,
		REG_INERTIA_X    = 3'd4,
		REG_INERTIA_Y    = 3'd5,
		REG_INERTIA_Z    = 3'd6
	} reg_idx_t;

	// multiplier operand A
	typedef enum logic [3:0] {
		MA_W0, MA_W1, MA_W2, MA_IX, MA_IY, MA_IZ, MA_ACC,
		MA_FORCE, MA_PFORCE, MA_TERM, MA_A0, MA_A1, MA_A2
	} mul_a_t;

	// multiplier operand B
	typedef enum logic [3:0] {
		MB_A0, MB_A1, MB_A2, MB_ABS0, MB_ABS1, MB_ABS2,
		MB_INERT, MB_IGAIN, MB_DGAIN, MB_F, MB_FORCE
	} mul_b_t;

	// register write-back action of a step
	typedef enum logic [4:0] {
		WB_NONE, WB_LOAD, WB_SUM_SET, WB_SUM_ADD, WB_SPEED, WB_INERTIA,
		WB_ACC, WB_FORCE, WB_DIFF, WB_DIV1, WB_FADD, WB_FCALC, WB_TERM,
		WB_LIMIT, WB_STATE, WB_PACC, WB_T0, WB_T1, WB_T2, WB_OUT, WB_OUTZ
	} wb_t;

	// jump condition; taken -> tgt, else next step
	typedef enum logic [3:0] {
		BR_NEXT, BR_ALWAYS, BR_NO_INPUT, BR_CMD_ZERO, BR_PACC_ZERO,
		BR_DIV_BUSY, BR_DAMP, BR_NOT_STEADY, BR_INERT_ZERO, BR_OUT_FULL
	} br_t;

	typedef struct packed {
		mul_a_t ma;
		mul_b_t mb;
		wb_t    wb;
		br_t    br;
		step_t  tgt;
	} ucode_t;

	localparam step_t S_IDLE      = 6'd0;
	localparam step_t S_DIV1_WAIT = 6'd14;
	localparam step_t S_DAMP      = 6'd19;
	localparam step_t S_LIMIT     = 6'd24;
	localparam step_t S_DIV2_WAIT = 6'd26;
	localparam step_t S_TORQUE    = 6'd28;
	localparam step_t S_OUT       = 6'd32;
	localparam step_t S_ZOUT      = 6'd34;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX)
			return 32'sh7fffffff;
		else if (v < SAT_MIN)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic ucode_t uc(input mul_a_t ma, input mul_b_t mb, input wb_t wb,
		input br_t br, input step_t tgt);
		ucode_t w;
		w.ma  = ma;
		w.mb  = mb;
		w.wb  = wb;
		w.br  = br;
		w.tgt = tgt;
		return w;
	endfunction

	// Control store. Multiply issued at step n is consumed by the write-back of step n+1.
	function automatic ucode_t ucode_rom(input step_t s);
		case (s)
			6'd0:  return uc(MA_W0, MB_A0, WB_LOAD, BR_NO_INPUT, S_IDLE);
			6'd1:  return uc(MA_W0, MB_A0, WB_NONE, BR_CMD_ZERO, S_ZOUT);
			6'd2:  return uc(MA_W1, MB_A1, WB_SUM_SET, BR_NEXT, S_IDLE);
			6'd3:  return uc(MA_W2, MB_A2, WB_SUM_ADD, BR_NEXT, S_IDLE);
			6'd4:  return uc(MA_IX, MB_ABS0, WB_SPEED, BR_NEXT, S_IDLE);
			6'd5:  return uc(MA_IY, MB_ABS1, WB_SUM_SET, BR_NEXT, S_IDLE);
			6'd6:  return uc(MA_IZ, MB_ABS2, WB_SUM_ADD, BR_NEXT, S_IDLE);
			6'd7:  return uc(MA_W0, MB_A0, WB_INERTIA, BR_NEXT, S_IDLE);
			6'd8:  return uc(MA_W0, MB_A0, WB_ACC, BR_NEXT, S_IDLE);
			6'd9:  return uc(MA_ACC, MB_INERT, WB_NONE, BR_NEXT, S_IDLE);
			6'd10: return uc(MA_W0, MB_A0, WB_FORCE, BR_NEXT, S_IDLE);
			6'd11: return uc(MA_FORCE, MB_IGAIN, WB_DIFF, BR_NEXT, S_IDLE);
			6'd12: return uc(MA_W0, MB_A0, WB_FORCE, BR_NEXT, S_IDLE);
			6'd13: return uc(MA_W0, MB_A0, WB_DIV1, BR_PACC_ZERO, S_LIMIT);
			6'd14: return uc(MA_W0, MB_A0, WB_NONE, BR_DIV_BUSY, S_DIV1_WAIT);
			6'd15: return uc(MA_W0, MB_A0, WB_NONE, BR_DAMP, S_DAMP);
			6'd16: return uc(MA_W0, MB_A0, WB_NONE, BR_NOT_STEADY, S_LIMIT);
			6'd17: return uc(MA_PFORCE, MB_DGAIN, WB_NONE, BR_NEXT, S_IDLE);
			6'd18: return uc(MA_W0, MB_A0, WB_FADD, BR_ALWAYS, S_LIMIT);
			6'd19: return uc(MA_W0, MB_A0, WB_FCALC, BR_NEXT, S_IDLE);
			6'd20: return uc(MA_PFORCE, MB_F, WB_NONE, BR_NEXT, S_IDLE);
			6'd21: return uc(MA_W0, MB_A0, WB_TERM, BR_NEXT, S_IDLE);
			6'd22: return uc(MA_TERM, MB_DGAIN, WB_NONE, BR_NEXT, S_IDLE);
			6'd23: return uc(MA_W0, MB_A0, WB_FADD, BR_ALWAYS, S_LIMIT);
			6'd24: return uc(MA_W0, MB_A0, WB_LIMIT, BR_NEXT, S_IDLE);
			6'd25: return uc(MA_W0, MB_A0, WB_STATE, BR_INERT_ZERO, S_TORQUE);
			6'd26: return uc(MA_W0, MB_A0, WB_NONE, BR_DIV_BUSY, S_DIV2_WAIT);
			6'd27: return uc(MA_W0, MB_A0, WB_PACC, BR_NEXT, S_IDLE);
			6'd28: return uc(MA_A0, MB_FORCE, WB_NONE, BR_NEXT, S_IDLE);
			6'd29: return uc(MA_A1, MB_FORCE, WB_T0, BR_NEXT, S_IDLE);
			6'd30: return uc(MA_A2, MB_FORCE, WB_T1, BR_NEXT, S_IDLE);
			6'd31: return uc(MA_W0, MB_A0, WB_T2, BR_NEXT, S_IDLE);
			6'd32: return uc(MA_W0, MB_A0, WB_OUT, BR_OUT_FULL, S_OUT);
			6'd33: return uc(MA_W0, MB_A0, WB_NONE, BR_ALWAYS, S_IDLE);
			6'd34: return uc(MA_W0, MB_A0, WB_OUTZ, BR_OUT_FULL, S_ZOUT);
			default: return uc(MA_W0, MB_A0, WB_NONE, BR_ALWAYS, S_IDLE);
		endcase
	endfunction

endpackage

>>> hdl/motor_speed_torque_controller.sv
// Motor speed/torque controller: microcoded sequencer over one 32x32 multiplier and a divider.
// A zero command goes straight to a zero-torque beat; any other runs the full sequence,
// paced by up to two serial divisions in mstc_div, one quotient bit per cycle.
// Throughput: one beat at a time; the next beat is taken once the sequencer is back at step 0.
// Reset: registers take their reset values, speed/accel/force history cleared, no result held.
// Depends on mstc_pkg and mstc_div.
module motor_speed_torque_controller
	import mstc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// speed_command, orient_row_x, orient_row_y, orient_row_z, ang_vel_x, ang_vel_y, ang_vel_z
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// torque_x, torque_y, torque_z
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// applies_force
	output logic                   m_axis_tuser
);

	localparam int DVW = FRAC_BITS + 34;
	localparam logic [DVW-1:0] ONE_Q = DVW'(1) << FRAC_BITS;
	localparam logic [DVW-1:0] STEADY_BAND = DVW'((5 * (1 << FRAC_BITS) + 50) / 100);

	// configuration
	logic [REG_W-1:0]  max_torque_q;
	logic [REG_W-1:0]  inertia_gain_q;
	logic [REG_W-1:0]  damping_gain_q;
	logic [AXIS_W-1:0] axis_select_q;
	logic [REG_W-1:0]  inertia_x_q;
	logic [REG_W-1:0]  inertia_y_q;
	logic [REG_W-1:0]  inertia_z_q;

	// history
	logic signed [DATA_W-1:0] prev_speed_q;
	logic signed [DATA_W-1:0] prev_accel_q;
	logic signed [DATA_W-1:0] prev_force_q;

	// datapath
	logic signed [DATA_W-1:0] cmd_q;
	logic signed [ROW_W:0]    a_q [3];
	logic signed [DATA_W-1:0] w_q [3];
	logic signed [63:0]       sum_q;
	logic signed [63:0]       prod_q;
	logic signed [DATA_W-1:0] speed_q;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W-1:0] force_q;
	logic signed [DATA_W-1:0] term_q;
	logic [REG_W-1:0]         inertia_q;
	logic signed [DATA_W:0]   d_q;
	logic [FRAC_BITS:0]       f_q;
	logic signed [DATA_W-1:0] tq_q [3];

	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic                     m_tuser_q;

	step_t  step_q;
	step_t  step_d;
	ucode_t cw;
	logic   jump;

	logic signed [DATA_W-1:0] op_a;
	logic signed [DATA_W-1:0] op_b;
	logic signed [63:0]       prod_d;
	logic signed [63:0]       sum_nx;
	logic signed [63:0]       sum_sh;
	logic signed [63:0]       prod_sh;
	logic signed [ROW_W:0]    abs_a [3];
	logic signed [ROW_W:0]    row_in [3];
	logic                     neg_axis;
	logic                     out_free;
	logic                     cfg_we;

	logic                     div_start;
	logic                     div_busy;
	logic signed [DVW-1:0]    div_dividend;
	logic signed [DIVISOR_W-1:0] div_divisor;
	logic signed [DVW-1:0]    quot;
	logic [DVW-1:0]           q_abs;

	logic signed [DATA_W:0]   lim33;
	logic signed [DATA_W:0]   f33;

	assign pready        = 1'b1;
	assign cfg_we        = psel && penable && pwrite;
	assign s_axis_tready = step_q == S_IDLE;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign out_free      = !m_tvalid_q || m_axis_tready;

	assign neg_axis  = (axis_select_q >= AXIS_NEG_X) && (axis_select_q <= AXIS_NEG_Z);
	assign row_in[0] = (ROW_W+1)'(signed'(s_axis_tdata[49:32]));
	assign row_in[1] = (ROW_W+1)'(signed'(s_axis_tdata[67:50]));
	assign row_in[2] = (ROW_W+1)'(signed'(s_axis_tdata[85:68]));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			abs_a[k] = a_q[k][ROW_W] ? -a_q[k] : a_q[k];
		end
	end

	// read port
	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_MAX_TORQUE:   prdata = APB_DATA_W'(max_torque_q);
			REG_INERTIA_GAIN: prdata = APB_DATA_W'(inertia_gain_q);
			REG_DAMPING_GAIN: prdata = APB_DATA_W'(damping_gain_q);
			REG_AXIS_SELECT:  prdata = APB_DATA_W'(axis_select_q);
			REG_INERTIA_X:    prdata = APB_DATA_W'(inertia_x_q);
			REG_INERTIA_Y:    prdata = APB_DATA_W'(inertia_y_q);
			REG_INERTIA_Z:    prdata = APB_DATA_W'(inertia_z_q);
			default:          prdata = '0;
		endcase
	end

	// sequencer
	assign cw = ucode_rom(step_q);

	always_comb begin
		case (cw.br)
			BR_NEXT:       jump = 1'b0;
			BR_ALWAYS:     jump = 1'b1;
			BR_NO_INPUT:   jump = !s_axis_tvalid;
			BR_CMD_ZERO:   jump = cmd_q == '0;
			BR_PACC_ZERO:  jump = prev_accel_q == '0;
			BR_DIV_BUSY:   jump = div_busy;
			BR_DAMP:       jump = (d_q != '0) && (acc_q != '0) && (d_q[DATA_W] == acc_q[DATA_W-1]);
			BR_NOT_STEADY: jump = !((speed_q != '0) && (q_abs < STEADY_BAND));
			BR_INERT_ZERO: jump = inertia_q == '0;
			BR_OUT_FULL:   jump = !out_free;
			default:       jump = 1'b0;
		endcase
		step_d = jump ? cw.tgt : step_q + step_t'(1);
	end

	// multiplier operands
	always_comb begin
		case (cw.ma)
			MA_W0:     op_a = w_q[0];
			MA_W1:     op_a = w_q[1];
			MA_W2:     op_a = w_q[2];
			MA_IX:     op_a = signed'(DATA_W'(inertia_x_q));
			MA_IY:     op_a = signed'(DATA_W'(inertia_y_q));
			MA_IZ:     op_a = signed'(DATA_W'(inertia_z_q));
			MA_ACC:    op_a = acc_q;
			MA_FORCE:  op_a = force_q;
			MA_PFORCE: op_a = prev_force_q;
			MA_TERM:   op_a = term_q;
			MA_A0:     op_a = DATA_W'(a_q[0]);
			MA_A1:     op_a = DATA_W'(a_q[1]);
			MA_A2:     op_a = DATA_W'(a_q[2]);
			default:   op_a = '0;
		endcase
		case (cw.mb)
			MB_A0:    op_b = DATA_W'(a_q[0]);
			MB_A1:    op_b = DATA_W'(a_q[1]);
			MB_A2:    op_b = DATA_W'(a_q[2]);
			MB_ABS0:  op_b = DATA_W'(abs_a[0]);
			MB_ABS1:  op_b = DATA_W'(abs_a[1]);
			MB_ABS2:  op_b = DATA_W'(abs_a[2]);
			MB_INERT: op_b = signed'(DATA_W'(inertia_q));
			MB_IGAIN: op_b = signed'(DATA_W'(inertia_gain_q));
			MB_DGAIN: op_b = signed'(DATA_W'(damping_gain_q));
			MB_F:     op_b = signed'(DATA_W'(f_q));
			MB_FORCE: op_b = force_q;
			default:  op_b = '0;
		endcase
	end

	assign prod_d  = op_a * op_b;
	assign sum_nx  = sum_q + prod_q;
	// arithmetic shift rounds toward minus infinity
	assign sum_sh  = sum_nx >>> FRAC_BITS;
	assign prod_sh = prod_q >>> FRAC_BITS;

	// divider hookup: damping ratio first, then new acceleration
	assign div_start = ((cw.wb == WB_DIV1) && (prev_accel_q != '0))
		|| ((cw.wb == WB_STATE) && (inertia_q != '0));
	assign div_dividend = (cw.wb == WB_DIV1) ? (DVW'(d_q) <<< FRAC_BITS)
		: (DVW'(force_q) <<< FRAC_BITS);
	assign div_divisor = (cw.wb == WB_DIV1) ? prev_accel_q
		: signed'(DIVISOR_W'(inertia_q));
	assign q_abs = quot[DVW-1] ? DVW'(-quot) : DVW'(quot);

	mstc_div #(
		.DVW(DVW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.quotient(quot)
	);

	assign lim33 = signed'((DATA_W+1)'(max_torque_q));
	assign f33   = (DATA_W+1)'(force_q);

	// control, configuration and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= S_IDLE;
			m_tvalid_q     <= 1'b0;
			max_torque_q   <= '0;
			inertia_gain_q <= REG_W'(1) << FRAC_BITS;
			damping_gain_q <= REG_W'(1) << FRAC_BITS;
			axis_select_q  <= '0;
			inertia_x_q    <= REG_W'(1) << FRAC_BITS;
			inertia_y_q    <= REG_W'(1) << FRAC_BITS;
			inertia_z_q    <= REG_W'(1) << FRAC_BITS;
			prev_speed_q   <= '0;
			prev_accel_q   <= '0;
			prev_force_q   <= '0;
		end else begin
			step_q <= step_d;
			if ((cw.wb == WB_OUT || cw.wb == WB_OUTZ) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_MAX_TORQUE:   max_torque_q   <= pwdata[REG_W-1:0];
					REG_INERTIA_GAIN: inertia_gain_q <= pwdata[REG_W-1:0];
					REG_DAMPING_GAIN: damping_gain_q <= pwdata[REG_W-1:0];
					REG_AXIS_SELECT:  axis_select_q  <= pwdata[AXIS_W-1:0];
					REG_INERTIA_X:    inertia_x_q    <= pwdata[REG_W-1:0];
					REG_INERTIA_Y:    inertia_y_q    <= pwdata[REG_W-1:0];
					REG_INERTIA_Z:    inertia_z_q    <= pwdata[REG_W-1:0];
					default: ;
				endcase
			end
			if (cw.wb == WB_STATE) begin
				prev_force_q <= force_q;
				prev_speed_q <= speed_q;
				if (inertia_q == '0) begin
					prev_accel_q <= '0;
				end
			end else if (cw.wb == WB_PACC) begin
				prev_accel_q <= sat32(64'(quot));
			end
		end
	end

	// datapath write-back
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (cw.wb)
			WB_LOAD: begin
				if (s_axis_tvalid) begin
					cmd_q <= s_axis_tdata[31:0];
					for (int k = 0; k < 3; k++) begin
						a_q[k] <= neg_axis ? -row_in[k] : row_in[k];
					end
					w_q[0] <= s_axis_tdata[117:86];
					w_q[1] <= s_axis_tdata[149:118];
					w_q[2] <= s_axis_tdata[181:150];
				end
			end
			WB_SUM_SET: sum_q <= prod_q;
			WB_SUM_ADD: sum_q <= sum_nx;
			WB_SPEED:   speed_q <= sat32(sum_sh);
			WB_INERTIA: inertia_q <= (sum_sh > SAT_MAX) ? '1 : sum_sh[REG_W-1:0];
			WB_ACC:     acc_q <= sat32(64'(cmd_q) - 64'(speed_q));
			WB_FORCE:   force_q <= sat32(prod_sh);
			WB_DIFF:    d_q <= (DATA_W+1)'(speed_q) - (DATA_W+1)'(prev_speed_q);
			WB_FADD:    force_q <= sat32(64'(force_q) + prod_sh);
			WB_FCALC: begin
				// 1 - clamp(q, 0, 1)
				if (quot[DVW-1]) begin
					f_q <= ONE_Q[FRAC_BITS:0];
				end else if (DVW'(quot) > ONE_Q) begin
					f_q <= '0;
				end else begin
					f_q <= ONE_Q[FRAC_BITS:0] - quot[FRAC_BITS:0];
				end
			end
			WB_TERM: term_q <= prod_sh[DATA_W-1:0];
			WB_LIMIT: begin
				if (max_torque_q != '0) begin
					if (f33 > lim33) begin
						force_q <= lim33[DATA_W-1:0];
					end else if (f33 < -lim33) begin
						force_q <= DATA_W'(-lim33);
					end
				end
			end
			WB_T0: tq_q[0] <= sat32(prod_sh);
			WB_T1: tq_q[1] <= sat32(prod_sh);
			WB_T2: tq_q[2] <= sat32(prod_sh);
			WB_OUT: begin
				if (out_free) begin
					m_tdata_q <= {tq_q[2], tq_q[1], tq_q[0]};
					m_tuser_q <= 1'b1;
				end
			end
			WB_OUTZ: begin
				if (out_free) begin
					m_tdata_q <= '0;
					m_tuser_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// the divider is only ever launched idle and with a non-zero divisor
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!div_busy && div_divisor != '0))
		else $error("divider launched while busy or with zero divisor");

	a_zero_inertia: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.wb == WB_STATE && inertia_q == '0) |=> (prev_accel_q == '0))
		else $error("acceleration history not cleared for zero inertia");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.wb == WB_STATE && max_torque_q != '0) |-> (f33 <= lim33 && f33 >= -lim33))
		else $error("force outside torque limit");

	a_zero_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("non-zero torque on a no-force beat");

endmodule

>>> hdl/mstc_div.sv
// Bit-serial signed divider, quotient truncated toward zero, one quotient bit per cycle.
// Depends on mstc_pkg; used by motor_speed_torque_controller.
module mstc_div
	import mstc_pkg::*;
#(
	parameter int DVW = FRAC_BITS_DEF + 34
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [DVW-1:0]       dividend,
	input  logic signed [DIVISOR_W-1:0] divisor,
	output logic                        busy,
	output logic signed [DVW-1:0]       quotient
);

	localparam int CNT_W = $clog2(DVW + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DVW-1:0]       quo_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic                 neg_q;

	logic [DIVISOR_W:0]   rem_sh;
	logic                 ge;
	logic [DIVISOR_W:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[DVW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign busy     = cnt_q != '0;
	assign quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
			dvs_q <= divisor[DIVISOR_W-1] ? DIVISOR_W'(-divisor) : DIVISOR_W'(divisor);
			neg_q <= dividend[DVW-1] ^ divisor[DIVISOR_W-1];
		end else if (busy) begin
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			quo_q <= {quo_q[DVW-2:0], ge};
		end
	end

endmodule
